// ===== sv/fsfla_pkg.sv =====
// ----------------------------------------------------------------------------
// fsfla_pkg
// Shared types, constants and helpers of the fixed-slot free-list allocator.
// ----------------------------------------------------------------------------
`default_nettype none

package fsfla_pkg;

	localparam int MAX_SLOTS = 256;
	localparam int SLOT_W    = $clog2(MAX_SLOTS);   // index of one slot
	localparam int CNT_W     = SLOT_W + 1;          // slot count, link with null
	localparam int OFS_W     = 20;
	localparam int BLK_W     = 13;
	localparam int REGION_W  = 21;                  // slot_count * block_bytes
	localparam int DIVB_W    = 3;                   // bit index of the quotient
	localparam int CFG_IDX_W = 2;

	localparam logic [CNT_W-1:0] NIL_LINK  = CNT_W'(MAX_SLOTS);
	localparam logic [BLK_W-1:0] BLK_MIN   = BLK_W'(8);
	localparam logic [BLK_W-1:0] BLK_MAX   = BLK_W'(4096);
	localparam logic [BLK_W-1:0] BLK_RST   = BLK_W'(64);
	localparam logic [CNT_W-1:0] SLOTS_MIN = CNT_W'(1);
	localparam logic [CNT_W-1:0] SLOTS_MAX = CNT_W'(MAX_SLOTS);

	// operation codes
	localparam logic [1:0] FN_ALLOC = 2'd0;
	localparam logic [1:0] FN_FREE  = 2'd1;
	localparam logic [1:0] FN_CHECK = 2'd2;

	// result status codes
	localparam logic [2:0] ST_OK       = 3'd0;
	localparam logic [2:0] ST_NOFREE   = 3'd1;
	localparam logic [2:0] ST_RANGE    = 3'd2;
	localparam logic [2:0] ST_MISALIGN = 3'd3;
	localparam logic [2:0] ST_NOUSE    = 3'd4;

	// configuration register indexes
	localparam logic [CFG_IDX_W-1:0] CFG_BLOCK = CFG_IDX_W'(0);
	localparam logic [CFG_IDX_W-1:0] CFG_SLOTS = CFG_IDX_W'(1);

	typedef struct packed {
		logic [1:0]       func;
		logic [OFS_W-1:0] byte_offset;
	} req_t;

	typedef struct packed {
		logic [2:0]       status;
		logic [OFS_W-1:0] slot_offset;
		logic             in_range;
		logic [CNT_W-1:0] used_slots;
		logic             is_full;
		logic             is_partial;
		logic             is_empty;
	} rsp_t;

	// controller -> datapath
	typedef struct packed {
		logic              cap_in;
		logic              rd_head;
		logic              alloc_commit;
		logic              div_load;
		logic              div_step;
		logic [DIVB_W-1:0] div_bit;
		logic              free_commit;
		logic              set_status;
		logic [2:0]        status;
		logic              load_out;
	} cmd_t;

	// datapath -> controller
	typedef struct packed {
		logic alloc_ok;
		logic in_range;
		logic rem_zero;
		logic used_zero;
	} sts_t;

	function automatic logic [BLK_W-1:0] clamp_block(input logic [BLK_W-1:0] v);
		logic [BLK_W-1:0] r;
		r = v;
		if (v < BLK_MIN) r = BLK_MIN;
		if (v > BLK_MAX) r = BLK_MAX;
		return r;
	endfunction

	function automatic logic [CNT_W-1:0] clamp_slots(input logic [CNT_W-1:0] v);
		logic [CNT_W-1:0] r;
		r = v;
		if (v < SLOTS_MIN) r = SLOTS_MIN;
		if (v > SLOTS_MAX) r = SLOTS_MAX;
		return r;
	endfunction

endpackage

`default_nettype wire

// ===== sv/fsfla_ctrl.sv =====
// ----------------------------------------------------------------------------
// fsfla_ctrl
// Sequencer of the allocator: handshakes, operation flow, divider steps.
// ----------------------------------------------------------------------------
`default_nettype none

module fsfla_ctrl (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire logic                req_valid,
	input  wire logic [1:0]          func,
	output      logic                req_stall,
	output      logic                rsp_valid,
	input  wire logic                rsp_stall,
	input  wire fsfla_pkg::sts_t     sts,
	output      fsfla_pkg::cmd_t     cmd
);

	localparam logic [2:0] S_IDLE  = 3'd0;
	localparam logic [2:0] S_RD    = 3'd1;
	localparam logic [2:0] S_ALLOC = 3'd2;
	localparam logic [2:0] S_FCHK  = 3'd3;
	localparam logic [2:0] S_DIV   = 3'd4;
	localparam logic [2:0] S_FEVAL = 3'd5;
	localparam logic [2:0] S_DONE  = 3'd6;

	logic [2:0]                     state_q, state_d;
	logic [fsfla_pkg::DIVB_W-1:0]   cnt_q, cnt_d;
	logic                           rsp_valid_q;
	logic                           out_free;
	logic                           req_acc;

	assign req_stall = (state_q != S_IDLE);
	assign req_acc   = req_valid && !req_stall;
	assign rsp_valid = rsp_valid_q;
	assign out_free  = !rsp_valid_q || !rsp_stall;

	always_comb begin
		state_d = state_q;
		cnt_d   = cnt_q;
		cmd     = '0;
		cmd.div_bit = cnt_q;
		case (state_q)
			S_IDLE: begin
				if (req_acc) begin
					cmd.cap_in = 1'b1;
					case (func)
						fsfla_pkg::FN_ALLOC: state_d = S_RD;
						fsfla_pkg::FN_FREE:  state_d = S_FCHK;
						default:             state_d = S_DONE;
					endcase
				end
			end
			S_RD: begin
				cmd.rd_head = 1'b1;
				state_d     = S_ALLOC;
			end
			S_ALLOC: begin
				if (sts.alloc_ok) begin
					cmd.alloc_commit = 1'b1;
				end else begin
					cmd.set_status = 1'b1;
					cmd.status     = fsfla_pkg::ST_NOFREE;
				end
				state_d = S_DONE;
			end
			S_FCHK: begin
				if (!sts.in_range) begin
					cmd.set_status = 1'b1;
					cmd.status     = fsfla_pkg::ST_RANGE;
					state_d        = S_DONE;
				end else begin
					cmd.div_load = 1'b1;
					cnt_d        = '1;
					state_d      = S_DIV;
				end
			end
			S_DIV: begin
				cmd.div_step = 1'b1;
				if (cnt_q == '0) begin
					state_d = S_FEVAL;
				end else begin
					cnt_d = cnt_q - 1'b1;
				end
			end
			S_FEVAL: begin
				if (!sts.rem_zero) begin
					cmd.set_status = 1'b1;
					cmd.status     = fsfla_pkg::ST_MISALIGN;
				end else if (sts.used_zero) begin
					cmd.set_status = 1'b1;
					cmd.status     = fsfla_pkg::ST_NOUSE;
				end else begin
					cmd.free_commit = 1'b1;
				end
				state_d = S_DONE;
			end
			S_DONE: begin
				if (out_free) begin
					cmd.load_out = 1'b1;
					state_d      = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			cnt_q       <= '0;
			rsp_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			cnt_q   <= cnt_d;
			if (cmd.load_out) begin
				rsp_valid_q <= 1'b1;
			end else if (rsp_valid_q && !rsp_stall) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

endmodule

`default_nettype wire

// ===== sv/fsfla_dpath.sv =====
// ----------------------------------------------------------------------------
// fsfla_dpath
// Datapath: configuration, link memory, head and count, divider, result.
// ----------------------------------------------------------------------------
`default_nettype none

module fsfla_dpath (
	input  wire logic                                clk,
	input  wire logic                                arst_n,
	input  wire fsfla_pkg::req_t                     req,
	input  wire logic                                cfg_we,
	input  wire logic [fsfla_pkg::CFG_IDX_W-1:0]     cfg_index,
	input  wire logic [fsfla_pkg::BLK_W-1:0]         cfg_wdata,
	input  wire fsfla_pkg::cmd_t                     cmd,
	output      fsfla_pkg::sts_t                     sts,
	output      fsfla_pkg::rsp_t                     rsp
);

	// configuration, clamped on write
	logic [fsfla_pkg::BLK_W-1:0]    blk_q;
	logic [fsfla_pkg::CNT_W-1:0]    n_q;
	logic [fsfla_pkg::REGION_W-1:0] region_q;
	logic                           rebuild;

	// list state
	logic [fsfla_pkg::CNT_W-1:0]    head_q;
	logic [fsfla_pkg::CNT_W-1:0]    used_q;
	logic [fsfla_pkg::CNT_W-1:0]    link_mem [fsfla_pkg::MAX_SLOTS];
	logic [fsfla_pkg::MAX_SLOTS-1:0] vld_q;
	logic [fsfla_pkg::CNT_W-1:0]    link_rd_q;
	logic                           vld_rd_q;
	logic [fsfla_pkg::SLOT_W-1:0]   head_idx;
	logic [fsfla_pkg::CNT_W-1:0]    head_inc;
	logic [fsfla_pkg::CNT_W-1:0]    link_dflt;

	// item registers
	logic [1:0]                     func_q;
	logic [fsfla_pkg::OFS_W-1:0]    ofs_q;
	logic [2:0]                     status_q;
	logic [fsfla_pkg::OFS_W-1:0]    slot_ofs_q;
	logic [fsfla_pkg::REGION_W-1:0] prod_q;
	logic                           ok_q;
	logic                           range_ok;

	// divider
	logic [fsfla_pkg::OFS_W-1:0]    rem_q;
	logic [fsfla_pkg::SLOT_W-1:0]   quo_q;
	logic [fsfla_pkg::REGION_W-1:0] div_sh;
	logic [fsfla_pkg::REGION_W-1:0] div_diff;

	fsfla_pkg::rsp_t                rsp_d;
	fsfla_pkg::rsp_t                rsp_q;

	assign rebuild  = cfg_we && (cfg_index == fsfla_pkg::CFG_BLOCK ||
		cfg_index == fsfla_pkg::CFG_SLOTS);
	assign range_ok = {1'b0, ofs_q} < region_q;
	assign head_idx = head_q[fsfla_pkg::SLOT_W-1:0];
	assign head_inc = {1'b0, head_idx} + 1'b1;
	assign link_dflt = (head_inc < n_q) ? head_inc : fsfla_pkg::NIL_LINK;
	assign div_sh   = fsfla_pkg::REGION_W'(blk_q) << cmd.div_bit;
	assign div_diff = {1'b0, rem_q} - div_sh;

	assign sts.alloc_ok  = ok_q;
	assign sts.in_range  = range_ok;
	assign sts.rem_zero  = (rem_q == '0);
	assign sts.used_zero = (used_q == '0);

	// configuration and region size
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			blk_q    <= fsfla_pkg::BLK_RST;
			n_q      <= fsfla_pkg::SLOTS_MAX;
			region_q <= fsfla_pkg::REGION_W'(fsfla_pkg::BLK_RST) *
				fsfla_pkg::REGION_W'(fsfla_pkg::SLOTS_MAX);
		end else begin
			if (cfg_we && cfg_index == fsfla_pkg::CFG_BLOCK) begin
				blk_q <= fsfla_pkg::clamp_block(cfg_wdata);
			end
			if (cfg_we && cfg_index == fsfla_pkg::CFG_SLOTS) begin
				n_q <= fsfla_pkg::clamp_slots(cfg_wdata[fsfla_pkg::CNT_W-1:0]);
			end
			region_q <= fsfla_pkg::REGION_W'(blk_q) * fsfla_pkg::REGION_W'(n_q);
		end
	end

	// list head, used count and valid bits; an invalid entry reads as its
	// rebuilt link
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			head_q <= '0;
			used_q <= '0;
			vld_q  <= '0;
		end else if (rebuild) begin
			head_q <= '0;
			used_q <= '0;
			vld_q  <= '0;
		end else if (cmd.alloc_commit) begin
			head_q <= vld_rd_q ? link_rd_q : link_dflt;
			used_q <= used_q + 1'b1;
		end else if (cmd.free_commit) begin
			head_q       <= {1'b0, quo_q};
			used_q       <= used_q - 1'b1;
			vld_q[quo_q] <= 1'b1;
		end
	end

	// link memory
	always_ff @(posedge clk) begin
		if (cmd.free_commit) begin
			link_mem[quo_q] <= head_q;
		end
		if (cmd.rd_head) begin
			link_rd_q <= link_mem[head_idx];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			status_q <= fsfla_pkg::ST_OK;
			ok_q     <= 1'b0;
		end else if (cmd.cap_in) begin
			status_q <= fsfla_pkg::ST_OK;
			ok_q     <= 1'b0;
		end else begin
			if (cmd.set_status) begin
				status_q <= cmd.status;
			end
			if (cmd.rd_head) begin
				ok_q <= (head_q < n_q) && (used_q < n_q);
			end
		end
	end

	// item payload, divider, product
	always_ff @(posedge clk) begin
		if (cmd.cap_in) begin
			func_q     <= req.func;
			ofs_q      <= req.byte_offset;
			slot_ofs_q <= '0;
		end
		if (cmd.rd_head) begin
			vld_rd_q <= vld_q[head_idx];
			prod_q   <= fsfla_pkg::REGION_W'(head_idx) * fsfla_pkg::REGION_W'(blk_q);
		end
		if (cmd.alloc_commit) begin
			slot_ofs_q <= prod_q[fsfla_pkg::OFS_W-1:0];
		end
		if (cmd.div_load) begin
			rem_q <= ofs_q;
			quo_q <= '0;
		end else if (cmd.div_step) begin
			if (!div_diff[fsfla_pkg::REGION_W-1]) begin
				rem_q            <= div_diff[fsfla_pkg::OFS_W-1:0];
				quo_q[cmd.div_bit] <= 1'b1;
			end
		end
		if (cmd.load_out) begin
			rsp_q <= rsp_d;
		end
	end

	always_comb begin
		rsp_d             = '0;
		rsp_d.status      = status_q;
		rsp_d.slot_offset = slot_ofs_q;
		rsp_d.in_range    = (func_q == fsfla_pkg::FN_ALLOC) ? ok_q : range_ok;
		rsp_d.used_slots  = used_q;
		rsp_d.is_full     = (used_q >= n_q);
		rsp_d.is_partial  = (used_q < n_q) && (used_q != '0);
		rsp_d.is_empty    = (used_q == '0);
	end

	assign rsp = rsp_q;

endmodule

`default_nettype wire

// ===== sv/fixed_slot_free_list_allocator_core.sv =====
// One item is in flight at a time: a new request is taken only after the last result is
//   loaded into the response register. Free is the longest path, set by the restoring divider
//   with one quotient bit per cycle; an out-of-range free skips the divide.
// Reset (arst_n low) clears all control state and rebuilds the free list at once:
//   valid bits of the link memory clear, so every entry reads as its chained link.
// A write to the block or slot register rebuilds the list the same way.
// ----------------------------------------------------------------------------
// fixed_slot_free_list_allocator_core
// Slab allocator over equal slots kept as a LIFO list of next-slot links.
// ----------------------------------------------------------------------------
`default_nettype none

module fixed_slot_free_list_allocator_core (
	input  wire logic                                clk,
	input  wire logic                                arst_n,
	// request channel
	input  wire logic                                req_valid,
	output      logic                                req_stall,
	input  wire fsfla_pkg::req_t                     req,
	// response channel
	output      logic                                rsp_valid,
	input  wire logic                                rsp_stall,
	output      fsfla_pkg::rsp_t                     rsp,
	// configuration write port
	input  wire logic                                cfg_we,
	input  wire logic [fsfla_pkg::CFG_IDX_W-1:0]     cfg_index,
	input  wire logic [fsfla_pkg::BLK_W-1:0]         cfg_wdata
);

	// The controller walks each beat through its steps:
	//   allocate: read link of head, then pop head and bump the count
	//   free:     range check, 8-step divide for slot and remainder,
	//             then misalign / nothing-in-use checks and push
	//   check:    straight to the result
	// The datapath owns every register that holds list or item data.
	// The response register sits in the datapath; a new request is taken
	// while an earlier response still waits on rsp_stall.
	fsfla_pkg::cmd_t cmd;
	fsfla_pkg::sts_t sts;

	fsfla_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.func      (req.func),
		.req_stall (req_stall),
		.rsp_valid (rsp_valid),
		.rsp_stall (rsp_stall),
		.sts       (sts),
		.cmd       (cmd)
	);

	fsfla_dpath u_dpath (
		.clk       (clk),
		.arst_n    (arst_n),
		.req       (req),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_wdata (cfg_wdata),
		.cmd       (cmd),
		.sts       (sts),
		.rsp       (rsp)
	);

endmodule

`default_nettype wire

// ===== sv/fsfla_chk.sv =====
// ----------------------------------------------------------------------------
// fsfla_chk
// Port-level checks of the allocator, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module fsfla_chk (
	input wire logic            clk,
	input wire logic            arst_n,
	input wire logic            req_valid,
	input wire logic            req_stall,
	input wire fsfla_pkg::req_t req,
	input wire logic            rsp_valid,
	input wire logic            rsp_stall,
	input wire fsfla_pkg::rsp_t rsp
);

	// a stalled response beat holds
	a_rsp_hold: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp))
		else $error("response beat changed while stalled");

	// exactly one of full, partial, empty
	a_flags: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid |-> $onehot({rsp.is_full, rsp.is_partial, rsp.is_empty}))
		else $error("occupancy flags not exclusive");

	a_empty: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid |-> (rsp.is_empty == (rsp.used_slots == '0)))
		else $error("empty flag disagrees with used count");

	a_fail_ofs: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp.status != fsfla_pkg::ST_OK |-> rsp.slot_offset == '0)
		else $error("failed operation returned a slot offset");

	// one item at a time: after a request beat the next is held off
	a_one_item: assert property (@(posedge clk) disable iff (!arst_n)
		req_valid && !req_stall |=> req_stall)
		else $error("request taken on back-to-back cycles");

endmodule

bind fixed_slot_free_list_allocator_core fsfla_chk u_chk (.*);

`default_nettype wire

// ===== tb/tb_fixed_slot_free_list_allocator_core.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_fixed_slot_free_list_allocator_core
// Self-checking bench for the slab allocator core. A cycle-free predictor
// tracks the free list, the used count and the slot geometry. Each accepted
// response beat is compared field by field against the oldest prediction.
// A short directed pass runs first. Random phases follow over several slot
// geometries, with random idling on both channels and one long response
// hold-off that backs the core up.
// ----------------------------------------------------------------------------

module tb_fixed_slot_free_list_allocator_core;

	// func value 3 is not an operation of its own; the core treats it as a check
	localparam logic [1:0]                      FN_SPARE    = 2'd3;
	// register index with no register behind it; a write must change nothing
	localparam logic [fsfla_pkg::CFG_IDX_W-1:0] CFG_NONE    = fsfla_pkg::CFG_IDX_W'(3);
	localparam int                              CYCLE_LIMIT = 400000;
	localparam int                              HOLD_CYCLES = 300;
	localparam int                              TAIL_CYCLES = 16;
	localparam int                              REPORT_CAP  = 100;

	// ------------------------------------------------------------------------
	// Slot ledger: mirrors the free list and queues the response each request
	// must produce.
	// ------------------------------------------------------------------------
	class slot_ledger;
		logic [fsfla_pkg::CNT_W-1:0] link [fsfla_pkg::MAX_SLOTS];
		logic [fsfla_pkg::CNT_W-1:0] head;
		logic [fsfla_pkg::CNT_W-1:0] used;
		logic [fsfla_pkg::BLK_W-1:0] blk_reg;
		logic [fsfla_pkg::CNT_W-1:0] slots_reg;
		fsfla_pkg::rsp_t             awaited [$];
		int unsigned                 held [$];  // slots handed out and not yet returned
		int                          errors;
		int                          beats;
		int                          requests;
		int                          settings;
		int                          grants;
		int                          returns;
		int                          status_seen [8];

		function new();
			blk_reg   = fsfla_pkg::BLK_W'(64);
			slots_reg = fsfla_pkg::CNT_W'(256);
			relink();
		endfunction

		function int unsigned slot_bytes();
			if (blk_reg < 8) return 8;
			if (blk_reg > 4096) return 4096;
			return blk_reg;
		endfunction

		function int unsigned slot_total();
			if (slots_reg < 1) return 1;
			if (slots_reg > fsfla_pkg::MAX_SLOTS) return fsfla_pkg::MAX_SLOTS;
			return slots_reg;
		endfunction

		function int unsigned region_bytes();
			return slot_bytes() * slot_total();
		endfunction

		// chain slot i to i+1, last one to null, nothing handed out
		function void relink();
			int unsigned n;
			n = slot_total();
			for (int i = 0; i < fsfla_pkg::MAX_SLOTS; i++)
				link[i] = (i + 1 < n) ? fsfla_pkg::CNT_W'(i + 1) : fsfla_pkg::NIL_LINK;
			head = '0;
			used = '0;
			held.delete();
		endfunction

		function void write_reg(logic [fsfla_pkg::CFG_IDX_W-1:0] idx,
				logic [fsfla_pkg::BLK_W-1:0] val);
			settings++;
			if (idx == fsfla_pkg::CFG_BLOCK) begin
				blk_reg = val;
				relink();
			end else if (idx == fsfla_pkg::CFG_SLOTS) begin
				slots_reg = fsfla_pkg::CNT_W'(val[fsfla_pkg::CNT_W-1:0]);
				relink();
			end
		endfunction

		function void book_request(fsfla_pkg::req_t r);
			fsfla_pkg::rsp_t e;
			int unsigned     blk;
			int unsigned     n;
			int unsigned     ofs;
			int unsigned     s;
			blk = slot_bytes();
			n   = slot_total();
			ofs = r.byte_offset;
			e   = '0;
			e.status   = fsfla_pkg::ST_OK;
			e.in_range = (ofs < blk * n);
			requests++;
			if (r.func == fsfla_pkg::FN_ALLOC) begin
				if (head >= n || used >= n) begin
					e.status   = fsfla_pkg::ST_NOFREE;
					e.in_range = 1'b0;
				end else begin
					s             = head;
					e.slot_offset = fsfla_pkg::OFS_W'(s * blk);
					e.in_range    = 1'b1;
					head          = link[s];
					used          = used + 1'b1;
					held.push_back(s);
					grants++;
				end
			end else if (r.func == fsfla_pkg::FN_FREE) begin
				if (!e.in_range)
					e.status = fsfla_pkg::ST_RANGE;
				else if (ofs % blk != 0)
					e.status = fsfla_pkg::ST_MISALIGN;
				else if (used == 0)
					e.status = fsfla_pkg::ST_NOUSE;
				else begin
					// a double free is not caught: the slot just goes on the list again
					s       = ofs / blk;
					link[s] = head;
					head    = fsfla_pkg::CNT_W'(s);
					used    = used - 1'b1;
					foreach (held[k])
						if (held[k] == s) begin
							held.delete(k);
							break;
						end
					returns++;
				end
			end
			e.used_slots = used;
			e.is_full    = (used >= n);
			e.is_partial = (used != 0 && used < n);
			e.is_empty   = (used == 0);
			status_seen[e.status]++;
			awaited.push_back(e);
		endfunction

		function void compare(string field, logic [31:0] want, logic [31:0] got);
			if (want !== got) begin
				errors++;
				if (errors <= REPORT_CAP)
					$display("%0t ns: %s mismatch, expected %0d, got %0d",
						$time, field, want, got);
				if (errors == REPORT_CAP)
					$display("%0t ns: further mismatches counted, not shown", $time);
			end
		endfunction

		function void match_response(fsfla_pkg::rsp_t got);
			fsfla_pkg::rsp_t e;
			beats++;
			if (awaited.size() == 0) begin
				errors++;
				$display("%0t ns: response beat with nothing outstanding, got %p", $time, got);
				return;
			end
			e = awaited.pop_front();
			compare("status",      e.status,      got.status);
			compare("slot_offset", e.slot_offset, got.slot_offset);
			compare("in_range",    e.in_range,    got.in_range);
			compare("used_slots",  e.used_slots,  got.used_slots);
			compare("is_full",     e.is_full,     got.is_full);
			compare("is_partial",  e.is_partial,  got.is_partial);
			compare("is_empty",    e.is_empty,    got.is_empty);
		endfunction
	endclass

	// ------------------------------------------------------------------------
	// DUT hookup
	// ------------------------------------------------------------------------
	logic                            clk;
	logic                            arst_n;
	logic                            req_valid;
	logic                            req_stall;
	fsfla_pkg::req_t                 req;
	logic                            rsp_valid;
	logic                            rsp_stall;
	fsfla_pkg::rsp_t                 rsp;
	logic                            cfg_we;
	logic [fsfla_pkg::CFG_IDX_W-1:0] cfg_index;
	logic [fsfla_pkg::BLK_W-1:0]     cfg_wdata;

	fixed_slot_free_list_allocator_core dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_stall (req_stall),
		.req       (req),
		.rsp_valid (rsp_valid),
		.rsp_stall (rsp_stall),
		.rsp       (rsp),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_wdata (cfg_wdata)
	);

	slot_ledger ledger;
	bit         calm;           // last phase: no idling on either side
	bit         choke_req;      // ask the response side for one long hold-off
	int         no_gap_items;   // beats to offer back to back
	int         cycles;

	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	// Cycle budget. The slowest legal run is far below this: every beat a
	// free through the divider, plus the worst gap and stall bursts on every beat.
	initial begin : watchdog
		cycles = 0;
		while (cycles < CYCLE_LIMIT) begin
			@(posedge clk);
			cycles++;
		end
		$display("%0t ns: cycle limit reached, %0d responses still awaited",
			$time, ledger.awaited.size());
		$display("RESULT: ERROR");
		$finish;
	end

	// Response side. Each pass drives stall once and then waits on the clock
	// before the next, so stall never gets two updates in one step. Bursts of
	// stall alternate with open stretches; the long hold-off lets the request
	// side run into a full core.
	initial begin : rsp_side
		forever begin
			if (choke_req) begin
				choke_req = 1'b0;
				rsp_stall <= 1'b1;
				repeat (HOLD_CYCLES) @(posedge clk);
			end else if (!calm && $urandom_range(0, 3) == 0) begin
				rsp_stall <= 1'b1;
				repeat ($urandom_range(1, 14)) @(posedge clk);
			end else begin
				rsp_stall <= 1'b0;
				repeat ($urandom_range(1, 20)) @(posedge clk);
			end
		end
	end

	// Sample at the edge: a beat moves when valid is high and stall is low.
	always @(posedge clk)
		if (arst_n && rsp_valid && !rsp_stall)
			ledger.match_response(rsp);

	// ------------------------------------------------------------------------
	// Request side
	// ------------------------------------------------------------------------

	// Offer one request and hold it until the core takes it. Valid stays up
	// between back-to-back beats; a gap drops it for a burst of cycles first.
	task automatic send(input logic [1:0] func, input logic [fsfla_pkg::OFS_W-1:0] ofs);
		fsfla_pkg::req_t item;
		item.func        = func;
		item.byte_offset = ofs;
		if (no_gap_items > 0)
			no_gap_items--;
		else if (!calm && $urandom_range(0, 4) == 0) begin
			req_valid <= 1'b0;
			repeat ($urandom_range(1, 14)) @(posedge clk);
		end
		req_valid <= 1'b1;
		req       <= item;
		@(posedge clk);
		while (req_stall)
			@(posedge clk);
		ledger.book_request(item);
	endtask

	// Drop valid, then wait on the clock until every response is in.
	task automatic wait_drained();
		req_valid <= 1'b0;
		@(posedge clk);
		while (ledger.awaited.size() != 0)
			@(posedge clk);
	endtask

	// Registers are written only with the core idle; every response is in.
	// The write enable drops again, and the clock steps on before the task returns.
	task automatic write_reg(input logic [fsfla_pkg::CFG_IDX_W-1:0] idx,
			input logic [fsfla_pkg::BLK_W-1:0] val);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_wdata <= val;
		@(posedge clk);
		ledger.write_reg(idx, val);
		cfg_we    <= 1'b0;
		@(posedge clk);
	endtask

	// Boundary-heavy offset: fully random, exactly the region size, the last
	// byte inside it, or anywhere inside (mostly misaligned).
	function automatic logic [fsfla_pkg::OFS_W-1:0] pick_offset();
		int unsigned region;
		region = ledger.region_bytes();
		case ($urandom_range(0, 3))
			0:       return fsfla_pkg::OFS_W'($urandom);
			1:       return fsfla_pkg::OFS_W'(region);
			2:       return fsfla_pkg::OFS_W'(region - 1);
			default: return fsfla_pkg::OFS_W'($urandom_range(0, region - 1));
		endcase
	endfunction

	// Mostly well-formed traffic: allocations and frees of slots really held,
	// with a share of double frees, bad offsets and range checks mixed in.
	task automatic random_item(input int alloc_pct);
		int unsigned r;
		int unsigned s;
		r = $urandom_range(0, 99);
		if (r < alloc_pct) begin
			send(fsfla_pkg::FN_ALLOC, fsfla_pkg::OFS_W'($urandom));
			return;
		end
		r = $urandom_range(0, 99);
		if (r < 60 && ledger.held.size() != 0) begin
			s = ledger.held[$urandom_range(0, ledger.held.size() - 1)];
			send(fsfla_pkg::FN_FREE, fsfla_pkg::OFS_W'(s * ledger.slot_bytes()));
		end else if (r < 70) begin
			s = $urandom_range(0, ledger.slot_total() - 1);
			send(fsfla_pkg::FN_FREE, fsfla_pkg::OFS_W'(s * ledger.slot_bytes()));
		end else if (r < 80)
			send(fsfla_pkg::FN_FREE, pick_offset());
		else if (r < 92)
			send(fsfla_pkg::FN_CHECK, pick_offset());
		else
			send(FN_SPARE, pick_offset());
	endtask

	// One geometry. Alternate fill-heavy and drain-heavy stretches sized to
	// the slot count, so the list runs full and empty again.
	task automatic run_phase(input logic [fsfla_pkg::BLK_W-1:0] blk,
			input logic [fsfla_pkg::BLK_W-1:0] cnt, input int items, input bit squeeze);
		int stretch;
		wait_drained();
		write_reg(fsfla_pkg::CFG_BLOCK, blk);
		write_reg(fsfla_pkg::CFG_SLOTS, cnt);
		stretch = ledger.slot_total() * 3 / 2 + 8;
		for (int k = 0; k < items; k++) begin
			if (squeeze && k == 100) begin
				choke_req    = 1'b1;
				no_gap_items = 24;
			end
			random_item(((k / stretch) % 2 == 0) ? 90 : 20);
		end
	endtask

	initial begin : stimulus
		ledger       = new();
		calm         = 1'b0;
		choke_req    = 1'b0;
		no_gap_items = 0;
		arst_n    <= 1'b0;
		req_valid <= 1'b0;
		req       <= '0;
		cfg_we    <= 1'b0;
		cfg_index <= fsfla_pkg::CFG_BLOCK;
		cfg_wdata <= '0;
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed, reset geometry: 64-byte slots, 256 of them (16 KiB region).
		send(fsfla_pkg::FN_FREE,  fsfla_pkg::OFS_W'(0));       // nothing in use yet
		send(fsfla_pkg::FN_CHECK, fsfla_pkg::OFS_W'(0));
		send(fsfla_pkg::FN_CHECK, '1);                         // far outside the region
		send(fsfla_pkg::FN_FREE,  '1);                         // out of range
		send(fsfla_pkg::FN_ALLOC, '1);                         // offset ignored on allocate
		send(fsfla_pkg::FN_FREE,  fsfla_pkg::OFS_W'(1));       // misaligned
		send(fsfla_pkg::FN_FREE,  fsfla_pkg::OFS_W'(16384));   // first byte past the region
		send(FN_SPARE,            fsfla_pkg::OFS_W'(16383));   // spare code behaves as a check
		send(fsfla_pkg::FN_ALLOC, fsfla_pkg::OFS_W'(0));
		send(fsfla_pkg::FN_FREE,  fsfla_pkg::OFS_W'(0));
		send(fsfla_pkg::FN_FREE,  fsfla_pkg::OFS_W'(64));

		// Directed, smallest legal geometry: block size written as zero clamps
		// up to 8 bytes, two slots.
		wait_drained();
		write_reg(fsfla_pkg::CFG_BLOCK, '0);
		write_reg(fsfla_pkg::CFG_SLOTS, fsfla_pkg::BLK_W'(2));
		send(fsfla_pkg::FN_ALLOC, fsfla_pkg::OFS_W'(0));
		send(fsfla_pkg::FN_ALLOC, fsfla_pkg::OFS_W'(0));       // full after this
		send(fsfla_pkg::FN_ALLOC, fsfla_pkg::OFS_W'(0));       // list empty
		send(fsfla_pkg::FN_FREE,  fsfla_pkg::OFS_W'(8));
		send(fsfla_pkg::FN_FREE,  fsfla_pkg::OFS_W'(8));       // double free, slot pushed twice
		send(fsfla_pkg::FN_ALLOC, fsfla_pkg::OFS_W'(0));
		send(fsfla_pkg::FN_ALLOC, fsfla_pkg::OFS_W'(0));       // same slot again, looped list
		send(fsfla_pkg::FN_ALLOC, fsfla_pkg::OFS_W'(0));       // refused by the used-count guard
		send(fsfla_pkg::FN_FREE,  fsfla_pkg::OFS_W'(15));      // inside, misaligned
		send(fsfla_pkg::FN_FREE,  fsfla_pkg::OFS_W'(16));      // first byte past the region
		send(fsfla_pkg::FN_CHECK, fsfla_pkg::OFS_W'(20'h80000));

		// Random phases over the register extremes and odd sizes in between.
		run_phase(fsfla_pkg::BLK_W'(4096), fsfla_pkg::BLK_W'(256), 420, 1'b1); // fills offsets
		run_phase(fsfla_pkg::BLK_W'(8),    fsfla_pkg::BLK_W'(1),   150, 1'b0);
		run_phase('1,                      '1,                     300, 1'b0); // both clamp
		wait_drained();
		write_reg(CFG_NONE, '1);                                               // no register
		run_phase(fsfla_pkg::BLK_W'(13),   fsfla_pkg::BLK_W'(37),  250, 1'b0);
		run_phase(fsfla_pkg::BLK_W'(4095), fsfla_pkg::BLK_W'(255), 350, 1'b0);
		wait_drained();
		calm = 1'b1;
		run_phase(fsfla_pkg::BLK_W'(7),    fsfla_pkg::BLK_W'(3),   200, 1'b0); // clamps to 8

		// Let every outstanding beat land, then watch for strays.
		wait_drained();
		repeat (TAIL_CYCLES) @(posedge clk);

		$display("Covered %0d requests over %0d register writes: %0d slots granted, %0d returned.",
			ledger.requests, ledger.settings, ledger.grants, ledger.returns);
		$display("Refusals: %0d none free, %0d out of range, %0d misaligned, %0d nothing held.",
			ledger.status_seen[fsfla_pkg::ST_NOFREE], ledger.status_seen[fsfla_pkg::ST_RANGE],
			ledger.status_seen[fsfla_pkg::ST_MISALIGN], ledger.status_seen[fsfla_pkg::ST_NOUSE]);
		if (ledger.errors == 0 && ledger.awaited.size() == 0)
			$display("RESULT: OK");
		else
			$display("RESULT: ERROR");
		$finish;
	end

endmodule

// ===== filelist.f =====
sv/fsfla_pkg.sv
sv/fsfla_ctrl.sv
sv/fsfla_dpath.sv
sv/fixed_slot_free_list_allocator_core.sv
sv/fsfla_chk.sv
tb/tb_fixed_slot_free_list_allocator_core.sv
